/* sv/rgb2nv_pkg.sv */
`default_nettype none
package rgb2nv_pkg;

  // Configuration register.
  localparam int unsigned CFG_W       = 13;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;

  // Pair sums and line store entry.
  localparam int unsigned SUM_W   = 9;
  localparam int unsigned ENTRY_W = 2 * SUM_W;

  // Width of the intermediate chroma and luma sums.
  localparam int unsigned ACC_W = 17;

  // BT.601 integer coefficients (magnitudes, signs applied in the datapath).
  localparam logic [7:0] COEF_YR = 8'd66;
  localparam logic [7:0] COEF_YG = 8'd129;
  localparam logic [7:0] COEF_YB = 8'd25;
  localparam logic [7:0] COEF_UR = 8'd38;
  localparam logic [7:0] COEF_UG = 8'd74;
  localparam logic [7:0] COEF_UB = 8'd112;
  localparam logic [7:0] COEF_VR = 8'd112;
  localparam logic [7:0] COEF_VG = 8'd94;
  localparam logic [7:0] COEF_VB = 8'd18;
  localparam logic [7:0] ROUND_HALF  = 8'd128;
  localparam logic [7:0] LUMA_OFFSET = 8'd16;
  // Rounding term plus the chroma offset of 128 taken before the shift.
  localparam logic [ACC_W-1:0] CHROMA_BIAS = 17'd32896;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       start_of_frame;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
  } out_pixel_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } ycc_t;

  // Position of a pixel within its 2x2 block.
  typedef struct packed {
    logic odd_col;
    logic odd_row;
  } pos_tag_t;

endpackage
`default_nettype wire

/* sv/rgb2nv_color.sv */
`default_nettype none
module rgb2nv_color (
  input  wire logic [7:0]   red,
  input  wire logic [7:0]   green,
  input  wire logic [7:0]   blue,
  output rgb2nv_pkg::ycc_t  ycc
);
  import rgb2nv_pkg::*;

  logic [ACC_W-1:0] r_w, g_w, b_w;
  logic [ACC_W-1:0] y_sum, u_pos, u_neg, v_pos, v_neg, u_sum, v_sum;

  assign r_w = ACC_W'(red);
  assign g_w = ACC_W'(green);
  assign b_w = ACC_W'(blue);

  always_comb begin
    y_sum = r_w * ACC_W'(COEF_YR) + g_w * ACC_W'(COEF_YG) + b_w * ACC_W'(COEF_YB)
            + ACC_W'(ROUND_HALF);
    u_pos = b_w * ACC_W'(COEF_UB) + CHROMA_BIAS;
    u_neg = r_w * ACC_W'(COEF_UR) + g_w * ACC_W'(COEF_UG);
    v_pos = r_w * ACC_W'(COEF_VR) + CHROMA_BIAS;
    v_neg = g_w * ACC_W'(COEF_VG) + b_w * ACC_W'(COEF_VB);
    // The bias keeps both differences positive, so a plain shift is a floor shift.
    u_sum = u_pos - u_neg;
    v_sum = v_pos - v_neg;
    ycc.y = y_sum[15:8] + LUMA_OFFSET;
    ycc.u = u_sum[15:8];
    ycc.v = v_sum[15:8];
  end

endmodule
`default_nettype wire

/* sv/rgb2nv_line_store.sv */
`default_nettype none
module rgb2nv_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [rgb2nv_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                           rd_en,
  input  wire logic [AW-1:0]                  rd_addr,
  output logic      [rgb2nv_pkg::ENTRY_W-1:0] rd_data
);
  import rgb2nv_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* sv/rgb24_to_nv12_converter.sv */
`default_nettype none
// An accepted pixel is registered in stage A, then stage B, then the output register.
// Throughput: one pixel per cycle while out_stall is low; three pipeline registers with bubble collapse.
// The line store has one write and one read port, used at most once each per cycle.
// Reset (rst_n low at a rising edge) empties the pipeline, zeroes the column, row
// and held chroma, and loads image_width with 640. The line store is not cleared.
module rgb24_to_nv12_converter #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rgb2nv_pkg::in_pixel_t         in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rgb2nv_pkg::out_pixel_t             out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rgb2nv_pkg::CFG_W-1:0]  cfg_wr_data
);
  import rgb2nv_pkg::*;

  // Derived sizes. The largest usable width is MAX_WIDTH rounded down to even.
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned WW         = CFG_W + 1;
  localparam logic [WW-1:0] TOP_WIDTH = WW'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam logic [WW-1:0] MIN_WIDTH = WW'(2);

  // Configuration register.
  logic [CFG_W-1:0] image_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      image_width_r <= cfg_wr_data;
    end
  end

  // The effective width drops bit 0 and is clamped to the supported range.
  logic [WW-1:0] eff_width;

  always_comb begin
    eff_width = {1'b0, image_width_r[CFG_W-1:1], 1'b0};
    if (eff_width < MIN_WIDTH) begin
      eff_width = MIN_WIDTH;
    end
    if (eff_width > TOP_WIDTH) begin
      eff_width = TOP_WIDTH;
    end
  end

  // Pipeline handshake. Each stage takes a new beat when it is empty or when its
  // own beat moves on, so empty stages ahead of a waiting result still fill.
  logic a_vld_r, b_vld_r, out_vld_r;
  logic c_ready, b_ready, a_ready;
  logic a_move, b_move, in_take;

  assign c_ready  = !out_vld_r || !out_stall;
  assign b_ready  = !b_vld_r || c_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign b_move   = b_vld_r && c_ready;
  assign a_move   = a_vld_r && b_ready;
  assign in_take  = in_valid && a_ready;
  assign in_stall = !a_ready;

  // Raster position. A start-of-frame beat is column 0 of an even row, and the
  // column wraps, toggling the row, once it reaches the effective width.
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic          odd_row_r, odd_row_nxt, odd_row_cur;
  logic [WW-1:0] col_inc;

  always_comb begin
    col_cur     = in_data.start_of_frame ? '0 : col_r;
    odd_row_cur = in_data.start_of_frame ? 1'b0 : odd_row_r;
    col_inc     = WW'(col_cur) + WW'(1);
    if (col_inc >= eff_width) begin
      col_nxt     = '0;
      odd_row_nxt = !odd_row_cur;
    end else begin
      col_nxt     = CW'(col_inc);
      odd_row_nxt = odd_row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      odd_row_r <= 1'b0;
    end else if (in_take) begin
      col_r     <= col_nxt;
      odd_row_r <= odd_row_nxt;
    end
  end

  // Stage A: the accepted pixel, its block position and its line store entry.
  logic [7:0]    a_red_r, a_green_r, a_blue_r;
  pos_tag_t      a_tag_r;
  logic [AW-1:0] a_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_red_r         <= in_data.red;
      a_green_r       <= in_data.green;
      a_blue_r        <= in_data.blue;
      a_tag_r.odd_col <= col_cur[0];
      a_tag_r.odd_row <= odd_row_cur;
      a_idx_r         <= AW'(col_cur >> 1);
    end
  end

  // Per-pixel Y, U and V.
  ycc_t a_ycc;

  rgb2nv_color u_color (
    .red   (a_red_r),
    .green (a_green_r),
    .blue  (a_blue_r),
    .ycc   (a_ycc)
  );

  // Stage B. The line store is read as a beat enters this stage, so the read
  // data stays put for as long as the beat waits here.
  ycc_t          b_ycc_r;
  pos_tag_t      b_tag_r;
  logic [AW-1:0] b_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ready) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_ycc_r <= a_ycc;
      b_tag_r <= a_tag_r;
      b_idx_r <= a_idx_r;
    end
  end

  // Pair sums. The first pixel of a pair parks its U and V in the held registers
  // when it leaves stage B; the second pixel then finds them here.
  logic [7:0]         held_u_r, held_v_r;
  logic [SUM_W-1:0]   pair_u, pair_v;
  logic [ENTRY_W-1:0] rd_entry;
  logic [SUM_W:0]     block_u, block_v;
  logic               store_wr, chroma_out;

  assign pair_u     = SUM_W'(held_u_r) + SUM_W'(b_ycc_r.u);
  assign pair_v     = SUM_W'(held_v_r) + SUM_W'(b_ycc_r.v);
  assign block_u    = (SUM_W+1)'(pair_u) + (SUM_W+1)'(rd_entry[ENTRY_W-1:SUM_W]);
  assign block_v    = (SUM_W+1)'(pair_v) + (SUM_W+1)'(rd_entry[SUM_W-1:0]);
  assign store_wr   = b_move && b_tag_r.odd_col && !b_tag_r.odd_row;
  assign chroma_out = b_tag_r.odd_col && b_tag_r.odd_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_u_r <= '0;
      held_v_r <= '0;
    end else if (b_move && !b_tag_r.odd_col) begin
      held_u_r <= b_ycc_r.u;
      held_v_r <= b_ycc_r.v;
    end
  end

  // An even row writes an entry when its beat leaves stage B; the odd row reads it
  // at least one row, and so at least two beats, later. Because a beat enters
  // stage B no earlier than the previous one leaves, the write always lands first.
  rgb2nv_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (b_idx_r),
    .wr_data ({pair_u, pair_v}),
    .rd_en   (a_move),
    .rd_addr (a_idx_r),
    .rd_data (rd_entry)
  );

  // Output register.
  out_pixel_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (c_ready) begin
      out_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_data_r.luma         <= b_ycc_r.y;
      out_data_r.chroma_valid <= chroma_out;
      out_data_r.cb           <= chroma_out ? block_u[SUM_W:2] : '0;
      out_data_r.cr           <= chroma_out ? block_v[SUM_W:2] : '0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* sv/rgb2nv_checker.sv */
`default_nettype none
module rgb2nv_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire rgb2nv_pkg::out_pixel_t        out_data
);
  import rgb2nv_pkg::*;

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // Luma stays in the BT.601 range.
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.luma >= 8'd16 && out_data.luma <= 8'd235)
    else $error("luma out of range");

  // Chroma fields are zero on a beat without a finished block.
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chroma_valid |-> out_data.cb == 8'd0 && out_data.cr == 8'd0)
    else $error("chroma fields set without a block");

  // The input stalls only while a result beat is held up at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

bind rgb24_to_nv12_converter rgb2nv_checker u_rgb2nv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);
`default_nettype wire
